// File: hw/rtl/crc_pkg.sv
// ----------------------------------------------------------------------------
// crc_pkg
// Shared types, constants and elaboration-time helpers for the camera
// response curve pipeline.
// ----------------------------------------------------------------------------
package crc_pkg;

  typedef enum logic [1:0] {
    MODE_GAMMA   = 2'd0,
    MODE_SIGMOID = 2'd1,
    MODE_LINEAR  = 2'd2,
    MODE_INVALID = 2'd3
  } curve_mode_t;

  typedef struct packed {
    logic [31:0] exposure_red;
    logic [31:0] exposure_green;
    logic [31:0] exposure_blue;
    logic [31:0] alpha_in;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] level_red;
    logic signed [31:0] level_green;
    logic signed [31:0] level_blue;
    logic [31:0]        alpha_out;
    logic               bad_mode;
  } result_t;

  // Settings shared by all three colour channels.
  typedef struct packed {
    logic [31:0] iso_scale;
    logic [23:0] gamma_exponent;
    curve_mode_t curve_mode;
  } crc_cfg_t;

  localparam int LOG2_FRAC = 16;
  localparam int LOG2_LAT  = LOG2_FRAC + 1;
  localparam int EXP2_BITS = 16;
  localparam int EXP2_LAT  = EXP2_BITS + 1;
  localparam int DIV_Q_W   = 17;
  localparam int DIV_LAT   = DIV_Q_W;
  localparam int AFF_LAT   = 3;

  // Stage at which the exponential unit takes its operand, counted from
  // acceptance: product, log2, base register, log2, log register, gamma product.
  localparam int EXP_IN  = 2 * LOG2_LAT + 4;
  localparam int EXP_OUT = EXP_IN + EXP2_LAT;
  localparam int CH_LAT  = EXP_OUT + DIV_LAT + 1;

  localparam logic [47:0] CAP48     = 48'hFFFF_FFFF_FFFF;
  localparam logic [40:0] MAG_CLAMP = 41'h100_0000_0000;
  localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
  localparam logic [31:0] ONE_Q16   = 32'd65536;
  localparam logic [31:0] ONE_Q30   = 32'h4000_0000;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = x;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Entry k holds 2^(2^-(k+1)) in Q2.30.
  function automatic logic [31:0] exp2_rom(input int k);
    logic [63:0] r;
    r = isqrt64(64'h2000_0000_0000_0000);
    for (int j = 1; j < EXP2_BITS; j++) begin
      if (j <= k) begin
        r = isqrt64(r << 30);
      end
    end
    return r[31:0];
  endfunction

endpackage

// File: hw/rtl/crc_log2.sv
// ----------------------------------------------------------------------------
// crc_log2
// Pipelined base-2 logarithm: leading-one position and 16 fraction bits by
// repeated squaring of the normalised mantissa, one bit per stage.
// ----------------------------------------------------------------------------
module crc_log2 import crc_pkg::*; (
  input  logic        clk,
  input  logic [63:0] x,
  output logic [5:0]  msb,
  output logic [15:0] frac
);

  logic [5:0]  lead;
  logic [94:0] wide;
  logic [31:0] m_q  [LOG2_LAT];
  logic [5:0]  k_q  [LOG2_LAT];
  logic [15:0] fr_q [LOG2_LAT];

  always_comb begin
    lead = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) begin
        lead = 6'(i);
      end
    end
    wide = {x, 31'b0} >> lead;
  end

  always_ff @(posedge clk) begin
    m_q[0]  <= wide[31:0];
    k_q[0]  <= lead;
    fr_q[0] <= '0;
  end

  for (genvar j = 1; j < LOG2_LAT; j++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] m2;
    assign sq = 64'(m_q[j-1]) * 64'(m_q[j-1]);
    assign m2 = sq[63:31];
    always_ff @(posedge clk) begin
      m_q[j]  <= m2[32] ? m2[32:1] : m2[31:0];
      k_q[j]  <= k_q[j-1];
      fr_q[j] <= {fr_q[j-1][14:0], m2[32]};
    end
  end

  assign msb  = k_q[LOG2_LAT-1];
  assign frac = fr_q[LOG2_LAT-1];

endmodule

// File: hw/rtl/crc_exp2.sv
// ----------------------------------------------------------------------------
// crc_exp2
// Pipelined 2^t for signed Q18.16 t: one constant factor per fraction bit,
// then a shift by the integer part, saturated to 48 bits.
// ----------------------------------------------------------------------------
module crc_exp2 import crc_pkg::*; (
  input  logic               clk,
  input  logic signed [33:0] t,
  output logic [47:0]        e
);

  logic [31:0]        acc_q [EXP2_BITS];
  logic [15:0]        f_q   [EXP2_BITS];
  logic signed [17:0] n_q   [EXP2_BITS];
  logic               big_q [EXP2_BITS];

  for (genvar j = 0; j < EXP2_BITS; j++) begin : g_mul
    localparam logic [31:0] Rom = exp2_rom(j);
    logic [31:0]        acc_src;
    logic [15:0]        f_src;
    logic signed [17:0] n_src;
    logic               big_src;
    logic [63:0]        prod;
    if (j == 0) begin : g_first
      assign acc_src = ONE_Q30;
      assign f_src   = t[15:0];
      assign n_src   = t[33:16];
      assign big_src = ($signed(t[33:16]) >= 18'sd32);
    end else begin : g_next
      assign acc_src = acc_q[j-1];
      assign f_src   = f_q[j-1];
      assign n_src   = n_q[j-1];
      assign big_src = big_q[j-1];
    end
    assign prod = 64'(acc_src) * 64'(Rom);
    always_ff @(posedge clk) begin
      acc_q[j] <= f_src[EXP2_BITS-1-j] ? prod[61:30] : acc_src;
      f_q[j]   <= f_src;
      n_q[j]   <= n_src;
      big_q[j] <= big_src;
    end
  end

  logic [31:0]        acc_l;
  logic signed [17:0] n_l;
  logic [17:0]        sh_up;
  logic [17:0]        sh_dn;
  logic [48:0]        up;
  logic [47:0]        e_next;

  always_comb begin
    acc_l = acc_q[EXP2_BITS-1];
    n_l   = n_q[EXP2_BITS-1];
    sh_up = 18'(n_l - 18'sd14);
    sh_dn = 18'(18'sd14 - n_l);
    up    = {17'b0, acc_l} << sh_up[4:0];
    if (big_q[EXP2_BITS-1]) begin
      e_next = CAP48;
    end else if (n_l >= 18'sd14) begin
      e_next = (up > {1'b0, CAP48}) ? CAP48 : up[47:0];
    end else if (sh_dn > 18'd31) begin
      e_next = '0;
    end else begin
      e_next = {16'b0, acc_l >> sh_dn[4:0]};
    end
  end

  always_ff @(posedge clk) begin
    e <= e_next;
  end

endmodule

// File: hw/rtl/crc_div.sv
// ----------------------------------------------------------------------------
// crc_div
// Pipelined restoring divider for 2^32 / d, one quotient bit per stage.
// ----------------------------------------------------------------------------
module crc_div import crc_pkg::*; (
  input  logic                 clk,
  input  logic [48:0]          d,
  output logic [DIV_Q_W-1:0]   q
);

  logic [48:0]        rem_q [DIV_Q_W];
  logic [48:0]        d_q   [DIV_Q_W];
  logic [DIV_Q_W-1:0] q_q   [DIV_Q_W];

  for (genvar i = 0; i < DIV_Q_W; i++) begin : g_bit
    logic [48:0]        rem_src;
    logic [48:0]        d_src;
    logic [DIV_Q_W-1:0] q_src;
    logic [49:0]        trial;
    logic               ge;
    if (i == 0) begin : g_first
      // The numerator's bits above the quotient range start the remainder.
      assign rem_src = 49'd32768;
      assign d_src   = d;
      assign q_src   = '0;
    end else begin : g_next
      assign rem_src = rem_q[i-1];
      assign d_src   = d_q[i-1];
      assign q_src   = q_q[i-1];
    end
    assign trial = {rem_src, 1'b0};
    assign ge    = (trial >= {1'b0, d_src});
    always_ff @(posedge clk) begin
      rem_q[i] <= ge ? 49'(trial - {1'b0, d_src}) : trial[48:0];
      d_q[i]   <= d_src;
      q_q[i]   <= {q_src[DIV_Q_W-2:0], ge};
    end
  end

  assign q = q_q[DIV_Q_W-1];

endmodule

// File: hw/rtl/crc_affine.sv
// ----------------------------------------------------------------------------
// crc_affine
// Three-stage gain * u + bias with magnitude clamp and 32-bit saturation.
// ----------------------------------------------------------------------------
module crc_affine import crc_pkg::*; (
  input  logic               clk,
  input  logic signed [31:0] gain,
  input  logic [47:0]        u,
  input  logic signed [31:0] bias,
  output logic signed [31:0] level
);

  logic [31:0]        gm;
  logic [63:0]        p_hi;
  logic [47:0]        p_lo;
  logic               neg_a;
  logic signed [31:0] bias_a;
  logic [64:0]        mag;
  logic [40:0]        mag_b;
  logic               neg_b;
  logic signed [31:0] bias_b;
  logic signed [42:0] sval;
  logic signed [42:0] sum;

  assign gm = gain[31] ? (~gain + 32'd1) : gain;

  always_ff @(posedge clk) begin
    p_hi   <= 64'(gm) * 64'(u[47:16]);
    p_lo   <= 48'(gm) * 48'(u[15:0]);
    neg_a  <= gain[31];
    bias_a <= bias;
  end

  assign mag = 65'(p_hi) + 65'(p_lo[47:16]);

  always_ff @(posedge clk) begin
    mag_b  <= (mag > 65'(MAG_CLAMP)) ? MAG_CLAMP : mag[40:0];
    neg_b  <= neg_a;
    bias_b <= bias_a;
  end

  always_comb begin
    sval = neg_b ? -$signed({2'b0, mag_b}) : $signed({2'b0, mag_b});
    sum  = sval + 43'(bias_b);
  end

  always_ff @(posedge clk) begin
    if (sum > 43'sd2147483647) begin
      level <= 32'sh7FFF_FFFF;
    end else if (sum < -43'sd2147483648) begin
      level <= 32'sh8000_0000;
    end else begin
      level <= sum[31:0];
    end
  end

endmodule

// File: hw/rtl/crc_channel.sv
// ----------------------------------------------------------------------------
// crc_channel
// One colour channel: scaled exposure, gamma, sigmoid and linear curves, with
// the final level selected by the curve mode.
// ----------------------------------------------------------------------------
module crc_channel import crc_pkg::*; (
  input  logic               clk,
  input  crc_cfg_t           cfg,
  input  logic [63:0]        gain_bias,
  input  logic [31:0]        exposure,
  output logic signed [31:0] level
);

  localparam int XAt    = 1 + AFF_LAT;
  localparam int TmAt   = XAt + 1;
  localparam int LgAt   = 1 + LOG2_LAT + 1;
  localparam int GAt    = EXP_OUT + AFF_LAT;
  localparam int QAt    = EXP_OUT + DIV_LAT;
  localparam int TmDly  = EXP_IN - TmAt;
  localparam int PosDly = EXP_OUT - LgAt;
  localparam int XDly   = QAt - XAt;
  localparam int GDly   = QAt - GAt;

  logic signed [31:0] gain;
  logic signed [31:0] bias;
  logic [63:0]        p;

  assign gain = gain_bias[63:32];
  assign bias = gain_bias[31:0];

  always_ff @(posedge clk) begin
    p <= 64'(cfg.iso_scale) * 64'(exposure);
  end

  // Linear level, also the sigmoid argument.
  logic signed [31:0] x;
  logic [31:0]        xm;
  logic [63:0]        tprod;
  logic [31:0]        tm;
  logic               xneg;
  logic [32:0]        tm_d [TmDly];

  crc_affine u_aff_lin (
    .clk   (clk),
    .gain  (gain),
    .u     (p[63:16]),
    .bias  (bias),
    .level (x)
  );

  assign xm    = x[31] ? (~x + 32'd1) : x;
  assign tprod = 64'(xm) * 64'(LOG2E_Q30);

  always_ff @(posedge clk) begin
    tm   <= tprod[61:30];
    xneg <= x[31];
    tm_d[0] <= {xneg, tm};
    for (int i = 1; i < TmDly; i++) begin
      tm_d[i] <= tm_d[i-1];
    end
  end

  // Gamma: base = log2(P) - 32, then log2 of the base.
  logic [5:0]  ka;
  logic [15:0] fa;
  logic [20:0] lg;
  logic        pos;
  logic [5:0]  kb;
  logic [15:0] fb;

  crc_log2 u_log_a (
    .clk  (clk),
    .x    (p),
    .msb  (ka),
    .frac (fa)
  );

  always_ff @(posedge clk) begin
    pos <= (ka > 6'd32) || ((ka == 6'd32) && (fa != 16'd0));
    lg  <= {5'(ka - 6'd32), fa};
  end

  crc_log2 u_log_b (
    .clk  (clk),
    .x    ({43'b0, lg}),
    .msb  (kb),
    .frac (fb)
  );

  logic signed [6:0]  kd;
  logic signed [22:0] ll;
  logic [22:0]        ll_abs;
  logic [21:0]        lm;
  logic               llneg;
  logic [45:0]        smp;
  logic [29:0]        sm;
  logic               smneg;

  always_comb begin
    kd     = $signed({1'b0, kb}) - 7'sd16;
    ll     = {kd, fb};
    ll_abs = ll[22] ? 23'(-ll) : 23'(ll);
  end

  always_ff @(posedge clk) begin
    lm    <= ll_abs[21:0];
    llneg <= ll[22];
  end

  assign smp = 46'(cfg.gamma_exponent) * 46'(lm);

  always_ff @(posedge clk) begin
    sm    <= smp[45:16];
    smneg <= llneg;
  end

  // Shared exponential: gamma power or sigmoid term.
  logic [33:0]        t_mag;
  logic signed [33:0] t;
  logic [47:0]        e;
  logic               pos_d [PosDly];
  logic [47:0]        pw;

  always_comb begin
    if (cfg.curve_mode == MODE_GAMMA) begin
      t_mag = {4'b0, sm};
      t     = smneg ? -$signed(t_mag) : $signed(t_mag);
    end else begin
      t_mag = {2'b0, tm_d[TmDly-1][31:0]};
      t     = tm_d[TmDly-1][32] ? $signed(t_mag) : -$signed(t_mag);
    end
  end

  crc_exp2 u_exp (
    .clk (clk),
    .t   (t),
    .e   (e)
  );

  always_ff @(posedge clk) begin
    pos_d[0] <= pos;
    for (int i = 1; i < PosDly; i++) begin
      pos_d[i] <= pos_d[i-1];
    end
  end

  always_comb begin
    if (cfg.gamma_exponent == 24'd0) begin
      pw = 48'(ONE_Q16);
    end else if (pos_d[PosDly-1]) begin
      pw = e;
    end else begin
      pw = '0;
    end
  end

  logic signed [31:0] glevel;
  logic [DIV_Q_W-1:0] q;

  crc_affine u_aff_gam (
    .clk   (clk),
    .gain  (gain),
    .u     (pw),
    .bias  (bias),
    .level (glevel)
  );

  crc_div u_div (
    .clk (clk),
    .d   (49'(e) + 49'(ONE_Q16)),
    .q   (q)
  );

  logic signed [31:0] x_d [XDly];
  logic signed [31:0] g_d [GDly];

  always_ff @(posedge clk) begin
    x_d[0] <= x;
    for (int i = 1; i < XDly; i++) begin
      x_d[i] <= x_d[i-1];
    end
    g_d[0] <= glevel;
    for (int i = 1; i < GDly; i++) begin
      g_d[i] <= g_d[i-1];
    end
  end

  always_ff @(posedge clk) begin
    case (cfg.curve_mode)
      MODE_GAMMA:   level <= g_d[GDly-1];
      MODE_SIGMOID: level <= $signed(32'(q));
      MODE_LINEAR:  level <= x_d[XDly-1];
      default:      level <= '0;
    endcase
  end

endmodule

// File: hw/rtl/camera_response_curve.sv
// ----------------------------------------------------------------------------
// camera_response_curve
// Maps each pixel's red, green and blue exposures through a gamma, sigmoid or
// linear camera response curve in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
// A pixel transfer is taken on every rising edge where start is high and busy
// is low. busy is only raised while rst is asserted, so a new pixel may be
// offered on every cycle and the block sustains one pixel per clock.
// Each result appears on the result port for exactly one cycle, flagged by
// done. Every pixel passes in lock step through two 17-stage logarithm
// pipelines, the gamma product, a 17-stage exponential pipeline and the
// 17-stage divider that finishes the sigmoid curve.
// Results leave in the order that pixels arrived. The receiver must take each
// result in the cycle it is shown; there is no back-pressure, and none is
// needed since every stage advances on every clock.
// Settings are written over the APB port, one register per 8-byte slot, and
// must only be changed while no pixel is in flight. A synchronous reset
// empties the pipeline (no done strobes follow) and restores the default
// settings: ISO 1.0, gains 1.0, biases 0, gamma 1.0 and gamma mode.
// ----------------------------------------------------------------------------
module camera_response_curve import crc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  pixel_t      pixel,
  output logic        done,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam logic [2:0] REG_ISO_SCALE  = 3'd0;
  localparam logic [2:0] REG_RED_GB     = 3'd1;
  localparam logic [2:0] REG_GREEN_GB   = 3'd2;
  localparam logic [2:0] REG_BLUE_GB    = 3'd3;
  localparam logic [2:0] REG_GAMMA_EXP  = 3'd4;
  localparam logic [2:0] REG_CURVE_MODE = 3'd5;

  localparam logic [63:0] GB_RESET = 64'h0001_0000_0000_0000;

  // Settings registers.
  logic [31:0] iso_scale;
  logic [63:0] red_gain_bias;
  logic [63:0] green_gain_bias;
  logic [63:0] blue_gain_bias;
  logic [23:0] gamma_exponent;
  curve_mode_t curve_mode;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      iso_scale       <= ONE_Q16;
      red_gain_bias   <= GB_RESET;
      green_gain_bias <= GB_RESET;
      blue_gain_bias  <= GB_RESET;
      gamma_exponent  <= 24'(ONE_Q16);
      curve_mode      <= MODE_GAMMA;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_ISO_SCALE:  iso_scale       <= pwdata[31:0];
        REG_RED_GB:     red_gain_bias   <= pwdata;
        REG_GREEN_GB:   green_gain_bias <= pwdata;
        REG_BLUE_GB:    blue_gain_bias  <= pwdata;
        REG_GAMMA_EXP:  gamma_exponent  <= pwdata[23:0];
        REG_CURVE_MODE: curve_mode      <= curve_mode_t'(pwdata[1:0]);
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ISO_SCALE:  prdata = {32'b0, iso_scale};
      REG_RED_GB:     prdata = red_gain_bias;
      REG_GREEN_GB:   prdata = green_gain_bias;
      REG_BLUE_GB:    prdata = blue_gain_bias;
      REG_GAMMA_EXP:  prdata = {40'b0, gamma_exponent};
      REG_CURVE_MODE: prdata = {62'b0, curve_mode};
      default:        prdata = '0;
    endcase
  end

  crc_cfg_t cfg;

  assign cfg.iso_scale      = iso_scale;
  assign cfg.gamma_exponent = gamma_exponent;
  assign cfg.curve_mode     = curve_mode;

  // The pipeline never stalls, so the only time a pixel is refused is reset.
  assign busy = rst;

  // Valid bits travel alongside the channel pipelines.
  logic [CH_LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[CH_LAT-2:0], start && !busy};
    end
  end

  assign done = vld[CH_LAT-1];

  // Alpha rides in a delay line and is replaced by 1.0 in sigmoid mode at the
  // output register, alongside the invalid-mode flag.
  logic [31:0] alpha_d [CH_LAT-1];
  logic [31:0] alpha_q;
  logic        bad_q;

  always_ff @(posedge clk) begin
    alpha_d[0] <= pixel.alpha_in;
    for (int i = 1; i < CH_LAT - 1; i++) begin
      alpha_d[i] <= alpha_d[i-1];
    end
    alpha_q <= (curve_mode == MODE_SIGMOID) ? ONE_Q16 : alpha_d[CH_LAT-2];
    bad_q   <= (curve_mode == MODE_INVALID);
  end

  logic signed [31:0] lv_red;
  logic signed [31:0] lv_green;
  logic signed [31:0] lv_blue;

  crc_channel u_red (
    .clk       (clk),
    .cfg       (cfg),
    .gain_bias (red_gain_bias),
    .exposure  (pixel.exposure_red),
    .level     (lv_red)
  );

  crc_channel u_green (
    .clk       (clk),
    .cfg       (cfg),
    .gain_bias (green_gain_bias),
    .exposure  (pixel.exposure_green),
    .level     (lv_green)
  );

  crc_channel u_blue (
    .clk       (clk),
    .cfg       (cfg),
    .gain_bias (blue_gain_bias),
    .exposure  (pixel.exposure_blue),
    .level     (lv_blue)
  );

  assign result.level_red   = lv_red;
  assign result.level_green = lv_green;
  assign result.level_blue  = lv_blue;
  assign result.alpha_out   = alpha_q;
  assign result.bad_mode    = bad_q;

  // Every result transfer matches a pixel transfer taken the full pipeline latency earlier.
  a_done_follows_start : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, CH_LAT))
    else $error("result transfer without a matching pixel transfer");

  // The invalid-mode flag and the zeroed levels are chosen in the same cycle.
  a_bad_mode_zero : assert property (@(posedge clk) disable iff (rst)
    done && result.bad_mode |->
      (result.level_red == 0) && (result.level_green == 0) && (result.level_blue == 0))
    else $error("invalid mode result carries nonzero levels");

  // Reset flushes every pixel in flight.
  a_reset_flush : assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result transfer straight after reset");

endmodule

// File: tb/camera_response_curve_tb.sv
// ----------------------------------------------------------------------------
// camera_response_curve_tb
// Self-checking bench for the camera response curve: drives pixel transfers
// in bursts, writes settings over APB between phases, predicts every result
// in fixed point and compares each strobed result field by field.
// ----------------------------------------------------------------------------
module camera_response_curve_tb;
  import crc_pkg::*;

  localparam int REG_ISO   = 0;
  localparam int REG_RED   = 1;
  localparam int REG_GREEN = 2;
  localparam int REG_BLUE  = 3;
  localparam int REG_GAMMA = 4;
  localparam int REG_MODE  = 5;
  localparam int PIPE_DRAIN = 100;
  localparam longint CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  pixel_t      pixel = '0;
  logic        done;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  // Shadow copy of the settings, updated as each register write lands.
  logic [31:0] sh_iso;
  logic [63:0] sh_gb [3];
  logic [23:0] sh_gamma;
  curve_mode_t sh_mode;

  result_t     pending_levels [$];
  int          mismatches = 0;
  longint      cycle_count = 0;
  logic [63:0] exp_rom [16];

  camera_response_curve u_top (.*);

  always #5 clk = ~clk;

  // A hard ceiling on the run, well beyond the slowest legal schedule.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- arithmetic
  function automatic logic [63:0] sqrt_floor(input logic [63:0] x);
    logic [63:0] v, r, b;
    v = x; r = 0; b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2(x) less a fixed offset, in signed Q16.16; x is nonzero.
  function automatic longint log2_fix(input logic [63:0] x, input int off);
    int k;
    logic [63:0] m;
    longint frac;
    k = 63; frac = 0;
    while (k > 0 && !x[k]) k--;
    m = (k >= 31) ? (x >> (k - 31)) : (x << (31 - k));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return longint'(k - off) * 65536 + frac;
  endfunction

  function automatic logic [63:0] exp2_fix(input longint t);
    longint n;
    logic [63:0] f, acc, r;
    acc = 64'h1 << 30;
    if (t >= 0) n = t / 65536;
    else n = -longint'((64'(-t) + 64'hFFFF) >> 16);
    f = 64'(t - n * 65536) & 64'hFFFF;
    if (n >= 32) return 64'hFFFF_FFFF_FFFF;
    for (int k = 0; k < 16; k++)
      if (f[15 - k]) acc = (acc * exp_rom[k]) >> 30;
    if (n >= 14) begin
      r = acc << (n - 14);
      return (r > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : r;
    end
    if (14 - n >= 63) return 0;
    return acc >> (14 - n);
  endfunction

  function automatic longint gain_apply(input longint gain, input logic [63:0] u,
                                        input longint bias);
    logic [63:0] gm, mag;
    longint v;
    gm = (gain < 0) ? 64'(-gain) : 64'(gain);
    mag = gm * (u >> 16) + ((gm * (u & 64'hFFFF)) >> 16);
    if (mag > 64'h100_0000_0000) mag = 64'h100_0000_0000;
    v = (gain < 0) ? -longint'(mag) : longint'(mag);
    v = v + bias;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [31:0] channel_level(input logic [31:0] expo,
                                                input logic [63:0] gb);
    longint gain, bias, lg, ll, x, t;
    logic [63:0] p, pw, lm, sm, xm, tm;
    gain = longint'($signed(gb[63:32]));
    bias = longint'($signed(gb[31:0]));
    p = {32'h0, sh_iso} * {32'h0, expo};
    if (sh_mode == MODE_GAMMA) begin
      lg = (p == 0) ? 0 : log2_fix(p, 32);
      if (sh_gamma == 0) begin
        pw = 65536;
      end else if (lg <= 0) begin
        pw = 0;      // non-positive log: the base is clamped to zero
      end else begin
        ll = log2_fix(64'(lg), 16);
        lm = (ll < 0) ? 64'(-ll) : 64'(ll);
        sm = ({40'h0, sh_gamma} * lm) >> 16;
        pw = exp2_fix((ll < 0) ? -longint'(sm) : longint'(sm));
      end
      return 32'(gain_apply(gain, pw, bias));
    end
    x = gain_apply(gain, p >> 16, bias);
    if (sh_mode == MODE_LINEAR) return 32'(x);
    xm = (x < 0) ? 64'(-x) : 64'(x);
    tm = (xm * 64'(LOG2E_Q30)) >> 30;
    t = (x < 0) ? longint'(tm) : -longint'(tm);
    return 32'((64'h1 << 32) / (64'd65536 + exp2_fix(t)));
  endfunction

  function automatic result_t pixel_levels(input pixel_t px);
    result_t r;
    r = '0;
    r.alpha_out = px.alpha_in;
    if (sh_mode == MODE_INVALID) begin
      r.bad_mode = 1'b1;
      return r;
    end
    r.level_red   = channel_level(px.exposure_red, sh_gb[0]);
    r.level_green = channel_level(px.exposure_green, sh_gb[1]);
    r.level_blue  = channel_level(px.exposure_blue, sh_gb[2]);
    if (sh_mode == MODE_SIGMOID) r.alpha_out = ONE_Q16;
    return r;
  endfunction

  // ----------------------------------------------------------------- checking
  // Every strobed result is matched against the oldest outstanding prediction.
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        want = pending_levels.pop_front();
        if (result !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: r %h/%h g %h/%h b %h/%h a %h/%h bad %b/%b",
                     want.level_red, result.level_red,
                     want.level_green, result.level_green,
                     want.level_blue, result.level_blue,
                     want.alpha_out, result.alpha_out,
                     want.bad_mode, result.bad_mode);
        end
      end
    end
  end

  // ---------------------------------------------------------------- transfers
  task automatic write_setting(input int idx, input logic [63:0] val);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1; paddr = 6'(idx * 8); pwdata = val;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ISO:   sh_iso = val[31:0];
      REG_RED:   sh_gb[0] = val;
      REG_GREEN: sh_gb[1] = val;
      REG_BLUE:  sh_gb[2] = val;
      REG_GAMMA: sh_gamma = val[23:0];
      default:   sh_mode = curve_mode_t'(val[1:0]);
    endcase
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  // Offers one pixel; start stays high into the next call when back to back.
  task automatic send_pixel(input pixel_t px);
    pixel = px;
    start = 1;
    do @(posedge clk); while (busy);
    pending_levels.push_back(pixel_levels(px));
    @(negedge clk);
  endtask

  task automatic idle_cycles(input int n);
    start = 0;
    repeat (n) @(negedge clk);
  endtask

  // Let the pipeline empty before touching any setting.
  task automatic drain;
    start = 0;
    while (pending_levels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word;
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 32'h3_0000);
      3: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic pixel_t rand_pixel;
    pixel_t px;
    px.exposure_red = rand_word();
    px.exposure_green = rand_word();
    px.exposure_blue = rand_word();
    px.alpha_in = $urandom;
    return px;
  endfunction

  // Small gains and biases keep sigmoid and gamma out of saturation most of the time.
  function automatic logic [63:0] rand_gain_bias;
    logic [31:0] g, b;
    case ($urandom_range(0, 3))
      0: begin g = $urandom; b = $urandom; end
      default: begin
        g = 32'($signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000);
        b = 32'($signed($urandom_range(0, 32'h10_0000)) - 32'sh8_0000);
      end
    endcase
    return {g, b};
  endfunction

  // -------------------------------------------------------------------- tests
  task automatic test_directed;
    pixel_t px;
    logic [31:0] edges [6];
    edges = '{32'h0, 32'h1, 32'h1_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
    for (int m = 0; m < 4; m++) begin
      write_setting(REG_MODE, 64'(m));
      for (int i = 0; i < 6; i++) begin
        px = '{edges[i], edges[5 - i], edges[(i + 2) % 6], edges[i]};
        send_pixel(px);
      end
      drain();
    end
    // Zero exponent forces the power to one; then a huge exponent saturates.
    write_setting(REG_MODE, 64'(MODE_GAMMA));
    write_setting(REG_GAMMA, 64'h0);
    send_pixel('{32'h0, 32'h10_0000, 32'hFFFF_FFFF, 32'h5});
    drain();
    write_setting(REG_GAMMA, 64'hFF_FFFF);
    send_pixel('{32'h0, 32'h10_0000, 32'hFFFF_FFFF, 32'h5});
    drain();
  endtask

  task automatic test_random_phase(input int items);
    int burst;
    write_setting(REG_ISO, 64'(rand_word()));
    write_setting(REG_RED, rand_gain_bias());
    write_setting(REG_GREEN, rand_gain_bias());
    write_setting(REG_BLUE, rand_gain_bias());
    write_setting(REG_GAMMA, 64'($urandom_range(0, 24'hFF_FFFF)));
    write_setting(REG_MODE, 64'($urandom_range(0, 3)));
    while (items > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && items > 0) begin
        send_pixel(rand_pixel());
        burst--; items--;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 8));
    end
    drain();
  endtask

  task automatic test_register_extremes;
    write_setting(REG_ISO, 64'hFFFF_FFFF);
    write_setting(REG_RED, 64'h7FFF_FFFF_7FFF_FFFF);
    write_setting(REG_GREEN, 64'h8000_0000_8000_0000);
    write_setting(REG_BLUE, 64'h0);
    write_setting(REG_GAMMA, 64'h1);
    for (int m = 0; m < 4; m++) begin
      write_setting(REG_MODE, 64'(m));
      repeat (20) send_pixel(rand_pixel());
      drain();
    end
  endtask

  initial begin
    for (int k = 0; k < 16; k++)
      exp_rom[k] = (k == 0) ? sqrt_floor(64'h1 << 61) : sqrt_floor(exp_rom[k - 1] << 30);
    sh_iso = 32'h1_0000;
    sh_gb = '{64'h1 << 48, 64'h1 << 48, 64'h1 << 48};
    sh_gamma = 24'h1_0000;
    sh_mode = MODE_GAMMA;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    test_register_extremes();
    for (int ph = 0; ph < 20; ph++) test_random_phase(100);
    drain();
    repeat (PIPE_DRAIN) @(negedge clk);
    if (mismatches == 0 && pending_levels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/crc_pkg.sv
hw/rtl/crc_log2.sv
hw/rtl/crc_exp2.sv
hw/rtl/crc_div.sv
hw/rtl/crc_affine.sv
hw/rtl/crc_channel.sv
hw/rtl/camera_response_curve.sv
tb/camera_response_curve_tb.sv
